// ===== sv/pptm_pkg.sv =====
// Shared types, codes and constants for the per-task peak page table.
package pptm_pkg;

    localparam int P_TABLE_DEPTH = 32;
    localparam int P_COUNT_WIDTH = 48;

    localparam int PID_W   = 22;
    localparam int ID_W    = 16;
    localparam int ORDER_W = 4;
    localparam int RSS_W   = 32;

    localparam logic REG_ALLOC_ID = 1'b0;
    localparam logic REG_FREE_ID  = 1'b1;

    typedef enum logic [2:0] {
        ST_IGNORED    = 3'd0,
        ST_UPDATED    = 3'd1,
        ST_CREATED    = 3'd2,
        ST_DROPPED    = 3'd3,
        ST_FULL       = 3'd4,
        ST_DUMP_ENTRY = 3'd5,
        ST_DUMP_END   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_UPD,
        S_DUMP,
        S_DUMP_END
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } t_cell_op;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

// ===== sv/pptm_cell.sv =====
// One table cell: holds one entry, compares it to the query pid, shifts with its neighbors.
module pptm_cell #(
    parameter int COUNT_WIDTH = pptm_pkg::P_COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pptm_pkg::t_cell_op              i_op,
    input  logic [pptm_pkg::PID_W-1:0]      i_query_pid,
    input  logic                            i_prev_valid,
    input  logic [pptm_pkg::PID_W-1:0]      i_prev_pid,
    input  logic signed [COUNT_WIDTH-1:0]   i_prev_cur,
    input  logic [COUNT_WIDTH-2:0]          i_prev_peak,
    input  logic                            i_next_valid,
    input  logic [pptm_pkg::PID_W-1:0]      i_next_pid,
    input  logic signed [COUNT_WIDTH-1:0]   i_next_cur,
    input  logic [COUNT_WIDTH-2:0]          i_next_peak,
    input  logic [pptm_pkg::PID_W-1:0]      i_wr_pid,
    input  logic signed [COUNT_WIDTH-1:0]   i_wr_cur,
    input  logic [COUNT_WIDTH-2:0]          i_wr_peak,
    output logic                            o_valid,
    output logic [pptm_pkg::PID_W-1:0]      o_pid,
    output logic signed [COUNT_WIDTH-1:0]   o_cur,
    output logic [COUNT_WIDTH-2:0]          o_peak,
    output pptm_pkg::t_cell_flags           o_flags
);
    import pptm_pkg::*;

    logic                          r_valid;
    logic [PID_W-1:0]              r_pid;
    logic signed [COUNT_WIDTH-1:0] r_cur;
    logic [COUNT_WIDTH-2:0]        r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_op)
                CELL_WRITE:     r_valid <= 1'b1;
                CELL_FROM_PREV: r_valid <= i_prev_valid;
                CELL_FROM_NEXT: r_valid <= i_next_valid;
                default:        r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_WRITE: begin
                r_pid  <= i_wr_pid;
                r_cur  <= i_wr_cur;
                r_peak <= i_wr_peak;
            end
            CELL_FROM_PREV: begin
                r_pid  <= i_prev_pid;
                r_cur  <= i_prev_cur;
                r_peak <= i_prev_peak;
            end
            CELL_FROM_NEXT: begin
                r_pid  <= i_next_pid;
                r_cur  <= i_next_cur;
                r_peak <= i_next_peak;
            end
            default: begin
                r_pid  <= r_pid;
                r_cur  <= r_cur;
                r_peak <= r_peak;
            end
        endcase
    end

    assign o_flags.lt = r_valid && (r_pid < i_query_pid);
    assign o_flags.eq = r_valid && (r_pid == i_query_pid);
    assign o_valid    = r_valid;
    assign o_pid      = r_pid;
    assign o_cur      = r_cur;
    assign o_peak     = r_peak;

endmodule

// ===== sv/pptm_update.sv =====
// Shared page count updater: saturating add or subtract of 2^order, peak tracking.
module pptm_update #(
    parameter int COUNT_WIDTH = pptm_pkg::P_COUNT_WIDTH
) (
    input  logic                            i_inc,
    input  logic [pptm_pkg::ORDER_W-1:0]    i_order,
    input  logic signed [COUNT_WIDTH-1:0]   i_cur,
    input  logic [COUNT_WIDTH-2:0]          i_peak,
    output logic signed [COUNT_WIDTH-1:0]   o_cur,
    output logic [COUNT_WIDTH-2:0]          o_peak
);
    import pptm_pkg::*;

    logic signed [COUNT_WIDTH:0] cur_x;
    logic signed [COUNT_WIDTH:0] delta;
    logic signed [COUNT_WIDTH:0] sum;

    always_comb begin
        cur_x = {i_cur[COUNT_WIDTH-1], i_cur};
        delta = (COUNT_WIDTH+1)'(1) << i_order;
        sum   = i_inc ? (cur_x + delta) : (cur_x - delta);
        if (sum[COUNT_WIDTH] == sum[COUNT_WIDTH-1]) begin
            o_cur = sum[COUNT_WIDTH-1:0];
        end else if (i_inc) begin
            o_cur = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
        end else begin
            o_cur = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
        end
        if (i_inc && !o_cur[COUNT_WIDTH-1] && (o_cur[COUNT_WIDTH-2:0] > i_peak)) begin
            o_peak = o_cur[COUNT_WIDTH-2:0];
        end else begin
            o_peak = i_peak;
        end
    end

endmodule

// ===== sv/per_task_peak_memory_table.sv =====
// Top level of the per-task peak page table: control, cell chain and result register.
//
// Commands enter on i_start when o_busy is low. i_command 0 is a trace event, 1 a dump.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to the register picked by i_cfg_index
// (0 alloc event id, 1 free event id). The user must write only while no command is
// in flight; the block does not enforce it. Results appear on the o_ result ports for
// one cycle with o_valid high; the receiver cannot stall, so every result must be taken
// in that cycle. Trace event: one result, registered onto the ports after cell compare
// and select (S_FIND), then update and write-back into the chain (S_UPD). A new command
// is taken during the write-back state, so the next event overlaps the write-back.
// Dump: the chain rotates by one cell per cycle until each cell has passed cell 0; each
// valid entry is emitted in pid order as it passes cell 0, then the end marker follows.
// The next command is taken with the end marker.
// Insertion keeps the chain sorted: the cell at the insert point takes the new entry and
// the cells after it take their left neighbor in the write-back cycle.
// Reset (synchronous, active low) clears all valid bits, the entry count and both ids.
module per_task_peak_memory_table #(
    parameter int TABLE_DEPTH = pptm_pkg::P_TABLE_DEPTH,
    parameter int COUNT_WIDTH = pptm_pkg::P_COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic [pptm_pkg::ID_W-1:0]       i_cfg_wdata,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_command,
    input  logic [pptm_pkg::ID_W-1:0]       i_event_id,
    input  logic [pptm_pkg::PID_W-1:0]      i_task_pid,
    input  logic [pptm_pkg::ORDER_W-1:0]    i_order,
    input  logic                            i_task_present,
    input  logic [pptm_pkg::RSS_W-1:0]      i_initial_rss,
    output logic                            o_valid,
    output logic [2:0]                      o_status,
    output logic [pptm_pkg::PID_W-1:0]      o_entry_pid,
    output logic signed [COUNT_WIDTH-1:0]   o_current_pages,
    output logic [COUNT_WIDTH-2:0]          o_peak_pages,
    output logic                            o_last
);
    import pptm_pkg::*;

    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam logic [64:0] CNT_MAX_X = (65'd1 << (COUNT_WIDTH - 1)) - 65'd1;

    t_state r_state, n_state;
    logic   accept;

    logic [ID_W-1:0] r_alloc_id, r_free_id;

    logic               r_q_evt, r_q_inc, r_q_present;
    logic [PID_W-1:0]   r_q_pid;
    logic [ORDER_W-1:0] r_q_order;
    logic [RSS_W-1:0]   r_q_rss;

    logic [CNTW-1:0] r_count, n_count;
    logic [CNTW-1:0] r_dump_cnt, n_dump_cnt;

    logic                          c_valid [TABLE_DEPTH];
    logic [PID_W-1:0]              c_pid   [TABLE_DEPTH];
    logic signed [COUNT_WIDTH-1:0] c_cur   [TABLE_DEPTH];
    logic [COUNT_WIDTH-2:0]        c_peak  [TABLE_DEPTH];
    t_cell_flags                   c_flags [TABLE_DEPTH];
    t_cell_op                      cell_op [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0]        lt_vec, eq_vec, valid_vec;
    logic signed [COUNT_WIDTH-1:0] sel_cur;
    logic [COUNT_WIDTH-2:0]        sel_peak;

    logic [TABLE_DEPTH-1:0]        r_lt, r_eq;
    logic                          r_hit;
    logic signed [COUNT_WIDTH-1:0] r_sel_cur;
    logic [COUNT_WIDTH-2:0]        r_sel_peak;

    logic [TABLE_DEPTH:0]          lt_shift;
    logic                          full, do_insert;
    logic [64:0]                   rss_x;
    logic signed [COUNT_WIDTH-1:0] seed, upd_in_cur, upd_cur;
    logic [COUNT_WIDTH-2:0]        upd_in_peak, upd_peak;

    logic                          n_valid, n_last;
    t_status                       n_status;
    logic [PID_W-1:0]              n_pid;
    logic signed [COUNT_WIDTH-1:0] n_cur;
    logic [COUNT_WIDTH-2:0]        n_peak;

    assign o_busy = !(r_state == S_IDLE || r_state == S_UPD || r_state == S_DUMP_END);
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_id <= '0;
            r_free_id  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ALLOC_ID: r_alloc_id <= i_cfg_wdata;
                REG_FREE_ID:  r_free_id  <= i_cfg_wdata;
                default:      r_alloc_id <= r_alloc_id;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q_evt     <= (i_event_id == r_alloc_id) || (i_event_id == r_free_id);
            r_q_inc     <= (i_event_id == r_alloc_id);
            r_q_present <= i_task_present;
            r_q_pid     <= i_task_pid;
            r_q_order   <= i_order;
            r_q_rss     <= i_initial_rss;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            localparam int NX = (gi + 1) % TABLE_DEPTH;
            logic                          pv_valid;
            logic [PID_W-1:0]              pv_pid;
            logic signed [COUNT_WIDTH-1:0] pv_cur;
            logic [COUNT_WIDTH-2:0]        pv_peak;
            if (gi == 0) begin : g_first
                assign pv_valid = 1'b1;
                assign pv_pid   = r_q_pid;
                assign pv_cur   = upd_cur;
                assign pv_peak  = upd_peak;
            end else begin : g_rest
                assign pv_valid = c_valid[gi-1];
                assign pv_pid   = c_pid[gi-1];
                assign pv_cur   = c_cur[gi-1];
                assign pv_peak  = c_peak[gi-1];
            end
            pptm_cell #(
                .COUNT_WIDTH(COUNT_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_op         (cell_op[gi]),
                .i_query_pid  (r_q_pid),
                .i_prev_valid (pv_valid),
                .i_prev_pid   (pv_pid),
                .i_prev_cur   (pv_cur),
                .i_prev_peak  (pv_peak),
                .i_next_valid (c_valid[NX]),
                .i_next_pid   (c_pid[NX]),
                .i_next_cur   (c_cur[NX]),
                .i_next_peak  (c_peak[NX]),
                .i_wr_pid     (r_q_pid),
                .i_wr_cur     (upd_cur),
                .i_wr_peak    (upd_peak),
                .o_valid      (c_valid[gi]),
                .o_pid        (c_pid[gi]),
                .o_cur        (c_cur[gi]),
                .o_peak       (c_peak[gi]),
                .o_flags      (c_flags[gi])
            );
            assign lt_vec[gi]    = c_flags[gi].lt;
            assign eq_vec[gi]    = c_flags[gi].eq;
            assign valid_vec[gi] = c_valid[gi];
        end
    endgenerate

    // matched entry, at most one cell hits
    always_comb begin
        sel_cur  = '0;
        sel_peak = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            sel_cur  = sel_cur  | (eq_vec[i] ? c_cur[i]  : '0);
            sel_peak = sel_peak | (eq_vec[i] ? c_peak[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIND) begin
            r_lt       <= lt_vec;
            r_eq       <= eq_vec;
            r_hit      <= |eq_vec;
            r_sel_cur  <= sel_cur;
            r_sel_peak <= sel_peak;
        end
    end

    always_comb begin
        rss_x       = 65'(r_q_rss);
        seed        = (rss_x > CNT_MAX_X) ? CNT_MAX_X[COUNT_WIDTH-1:0] : rss_x[COUNT_WIDTH-1:0];
        upd_in_cur  = r_hit ? r_sel_cur : seed;
        upd_in_peak = r_hit ? r_sel_peak : seed[COUNT_WIDTH-2:0];
        full        = (r_count == CNTW'(TABLE_DEPTH));
        do_insert   = r_q_evt && !r_hit && r_q_present && !full;
        lt_shift    = {r_lt, 1'b1};
    end

    pptm_update #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_update (
        .i_inc   (r_q_inc),
        .i_order (r_q_order),
        .i_cur   (upd_in_cur),
        .i_peak  (upd_in_peak),
        .o_cur   (upd_cur),
        .o_peak  (upd_peak)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FIND: n_state = S_UPD;
            S_DUMP: begin
                if (r_dump_cnt == CNTW'(TABLE_DEPTH - 1)) begin
                    n_state = S_DUMP_END;
                end
            end
            S_IDLE, S_UPD, S_DUMP_END: begin
                if (accept) begin
                    n_state = i_command ? S_DUMP : S_FIND;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid    = 1'b0;
        n_status   = ST_IGNORED;
        n_pid      = '0;
        n_cur      = '0;
        n_peak     = '0;
        n_last     = 1'b0;
        n_count    = r_count;
        n_dump_cnt = accept ? '0 : r_dump_cnt;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_op[i] = CELL_HOLD;
        end
        case (r_state)
            S_UPD: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                if (!r_q_evt) begin
                    n_status = ST_IGNORED;
                end else if (r_hit) begin
                    n_status = ST_UPDATED;
                    n_pid    = r_q_pid;
                    n_cur    = upd_cur;
                    n_peak   = upd_peak;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        cell_op[i] = r_eq[i] ? CELL_WRITE : CELL_HOLD;
                    end
                end else if (!r_q_present) begin
                    n_status = ST_DROPPED;
                    n_pid    = r_q_pid;
                end else if (full) begin
                    n_status = ST_FULL;
                    n_pid    = r_q_pid;
                end else begin
                    n_status = ST_CREATED;
                    n_pid    = r_q_pid;
                    n_cur    = upd_cur;
                    n_peak   = upd_peak;
                end
                if (do_insert) begin
                    n_count = r_count + 1'b1;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (!r_lt[i]) begin
                            cell_op[i] = lt_shift[i] ? CELL_WRITE : CELL_FROM_PREV;
                        end
                    end
                end
            end
            S_DUMP: begin
                n_valid    = c_valid[0];
                n_status   = ST_DUMP_ENTRY;
                n_pid      = c_pid[0];
                n_cur      = c_cur[0];
                n_peak     = c_peak[0];
                n_dump_cnt = r_dump_cnt + 1'b1;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    cell_op[i] = CELL_FROM_NEXT;
                end
            end
            S_DUMP_END: begin
                n_valid  = 1'b1;
                n_status = ST_DUMP_END;
                n_last   = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_dump_cnt <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dump_cnt <= n_dump_cnt;
            o_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_status        <= n_status;
        o_entry_pid     <= n_pid;
        o_current_pages <= n_cur;
        o_peak_pages    <= n_peak;
        o_last          <= n_last;
    end

    a_event_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_command) |=> ##2 (o_valid && o_last))
        else $error("trace event did not produce its result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DUMP) |-> ($countones(valid_vec) == int'(r_count)))
        else $error("entry count does not match valid cells");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DUMP) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("valid cells are not packed at the head of the chain");

endmodule

// ===== bench/per_task_peak_memory_table_tb.sv =====
// Self-checking testbench for the per-task peak page table: directed, random and table-full tests.
module per_task_peak_memory_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pptm_pkg::*;

    localparam int DEPTH = P_TABLE_DEPTH;
    localparam int CW    = P_COUNT_WIDTH;
    localparam logic signed [63:0] CNT_MAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] CNT_MIN = -CNT_MAX - 64'sd1;

    typedef struct {
        t_status           status;
        logic [PID_W-1:0]  pid;
        logic [CW-1:0]     cur;
        logic [CW-2:0]     peak;
        logic              last;
    } t_table_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic                    i_cfg_index;
    logic [ID_W-1:0]         i_cfg_wdata;
    logic                    i_start;
    logic                    o_busy;
    logic                    i_command;
    logic [ID_W-1:0]         i_event_id;
    logic [PID_W-1:0]        i_task_pid;
    logic [ORDER_W-1:0]      i_order;
    logic                    i_task_present;
    logic [RSS_W-1:0]        i_initial_rss;
    logic                    o_valid;
    logic [2:0]              o_status;
    logic [PID_W-1:0]        o_entry_pid;
    logic signed [CW-1:0]    o_current_pages;
    logic [CW-2:0]           o_peak_pages;
    logic                    o_last;

    // predicted table contents and settings
    logic [ID_W-1:0]         alloc_id;
    logic [ID_W-1:0]         free_id;
    logic [PID_W-1:0]        tbl_pid  [DEPTH];
    logic signed [63:0]      tbl_cur  [DEPTH];
    logic signed [63:0]      tbl_peak [DEPTH];
    int                      tbl_count;

    t_table_result           results_due [$];
    t_table_result           due;
    int                      fails;
    int                      idle_pct;

    per_task_peak_memory_table #(
        .TABLE_DEPTH (DEPTH),
        .COUNT_WIDTH (CW)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_event_id      (i_event_id),
        .i_task_pid      (i_task_pid),
        .i_order         (i_order),
        .i_task_present  (i_task_present),
        .i_initial_rss   (i_initial_rss),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_entry_pid     (o_entry_pid),
        .o_current_pages (o_current_pages),
        .o_peak_pages    (o_peak_pages),
        .o_last          (o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic void queue_result(input t_status st, input logic [PID_W-1:0] pid,
                                         input logic signed [63:0] cur,
                                         input logic signed [63:0] peak, input logic last);
        t_table_result r;
        r.status = st;
        r.pid    = pid;
        r.cur    = cur[CW-1:0];
        r.peak   = peak[CW-2:0];
        r.last   = last;
        results_due.push_back(r);
    endfunction

    function automatic void apply_table_item(input logic cmd, input logic [ID_W-1:0] id,
                                             input logic [PID_W-1:0] pid,
                                             input logic [ORDER_W-1:0] ord,
                                             input logic present,
                                             input logic [RSS_W-1:0] rss);
        int                 pos;
        logic               grow;
        logic signed [63:0] step;
        logic signed [63:0] cur;
        t_status            st;
        if (cmd) begin
            for (int i = 0; i < tbl_count; i++)
                queue_result(ST_DUMP_ENTRY, tbl_pid[i], tbl_cur[i], tbl_peak[i], 1'b0);
            queue_result(ST_DUMP_END, '0, '0, '0, 1'b1);
            return;
        end
        if (id != alloc_id && id != free_id) begin
            queue_result(ST_IGNORED, '0, '0, '0, 1'b1);
            return;
        end
        grow = (id == alloc_id);
        pos = 0;
        while (pos < tbl_count && tbl_pid[pos] < pid)
            pos++;
        if (pos < tbl_count && tbl_pid[pos] == pid) begin
            st = ST_UPDATED;
        end else begin
            if (!present) begin
                queue_result(ST_DROPPED, pid, '0, '0, 1'b1);
                return;
            end
            if (tbl_count >= DEPTH) begin
                queue_result(ST_FULL, pid, '0, '0, 1'b1);
                return;
            end
            for (int i = tbl_count; i > pos; i--) begin
                tbl_pid[i]  = tbl_pid[i-1];
                tbl_cur[i]  = tbl_cur[i-1];
                tbl_peak[i] = tbl_peak[i-1];
            end
            cur = $signed({32'd0, rss});
            if (cur > CNT_MAX)
                cur = CNT_MAX;
            tbl_pid[pos]  = pid;
            tbl_cur[pos]  = cur;
            tbl_peak[pos] = cur;
            tbl_count++;
            st = ST_CREATED;
        end
        step = 64'sd1 <<< ord;
        cur = tbl_cur[pos];
        if (grow) begin
            cur = (cur > CNT_MAX - step) ? CNT_MAX : cur + step;
            if (tbl_peak[pos] < cur)
                tbl_peak[pos] = cur;
        end else begin
            cur = (cur < CNT_MIN + step) ? CNT_MIN : cur - step;
        end
        tbl_cur[pos] = cur;
        queue_result(st, pid, cur, tbl_peak[pos], 1'b1);
    endfunction

    function automatic logic [PID_W-1:0] unused_pid();
        logic [PID_W-1:0] p;
        logic             hit;
        do begin
            p = PID_W'($urandom);
            hit = 1'b0;
            for (int i = 0; i < tbl_count; i++)
                if (tbl_pid[i] == p)
                    hit = 1'b1;
        end while (hit);
        return p;
    endfunction

    // i_start stays high on return; the next call either re-drives or lowers it
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [PID_W-1:0] pid, input logic [ORDER_W-1:0] ord,
                             input logic present, input logic [RSS_W-1:0] rss);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_command      <= cmd;
        i_event_id     <= id;
        i_task_pid     <= pid;
        i_order        <= ord;
        i_task_present <= present;
        i_initial_rss  <= rss;
        do @(posedge i_clk); while (o_busy);
        apply_table_item(cmd, id, pid, ord, present, rss);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_event_reg(input logic idx, input logic [ID_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == REG_ALLOC_ID)
            alloc_id = val;
        else
            free_id = val;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int               sel;
        logic [ID_W-1:0]  id;
        logic [PID_W-1:0] pid;
        logic [RSS_W-1:0] rss;
        if ($urandom_range(99) < 6) begin
            send_item(1'b1, ID_W'($urandom), PID_W'($urandom), ORDER_W'($urandom),
                      1'($urandom_range(1)), $urandom);
            return;
        end
        sel = $urandom_range(99);
        id = (sel < 45) ? alloc_id : (sel < 80) ? free_id : ID_W'($urandom);
        if (tbl_count > 0 && $urandom_range(99) < 65)
            pid = tbl_pid[$urandom_range(tbl_count - 1)];
        else
            pid = PID_W'($urandom);
        rss = $urandom_range(1) ? RSS_W'($urandom_range(64)) : RSS_W'($urandom);
        send_item(1'b0, id, pid, ORDER_W'($urandom), ($urandom_range(99) < 80), rss);
    endtask

    task automatic test_directed_events();
        idle_pct = 0;
        // both ids still zero: event id 0 counts as an alloc
        send_item(1'b1, '0, '0, '0, 1'b0, '0);
        send_item(1'b0, 16'h0000, 22'd100, 4'd0, 1'b1, 32'd10);
        drain_results();
        write_event_reg(REG_ALLOC_ID, 16'hFFFF);
        write_event_reg(REG_FREE_ID, 16'h0000);
        send_item(1'b0, 16'h1234, 22'd7, 4'd3, 1'b1, 32'd9);
        send_item(1'b0, 16'hFFFF, 22'h3FFFFF, 4'd0, 1'b0, 32'd1);
        send_item(1'b0, 16'hFFFF, 22'd0, 4'd0, 1'b1, 32'd0);
        send_item(1'b0, 16'h0000, 22'd0, 4'd15, 1'b0, 32'd0);
        send_item(1'b0, 16'hFFFF, 22'h3FFFFF, 4'd15, 1'b1, 32'hFFFF_FFFF);
        send_item(1'b0, 16'h0000, 22'h3FFFFF, 4'd0, 1'b0, 32'd0);
        send_item(1'b0, 16'hFFFF, 22'd100, 4'd15, 1'b0, 32'd0);
        send_item(1'b0, 16'h0000, 22'd200, 4'd3, 1'b1, 32'd5);
        send_item(1'b0, 16'hFFFF, 22'd0, 4'd15, 1'b1, 32'd0);
        send_item(1'b1, '0, '0, '0, 1'b0, '0);
        drain_results();
        write_event_reg(REG_ALLOC_ID, 16'h5A5A);
        write_event_reg(REG_FREE_ID, 16'hA5A5);
        send_item(1'b0, 16'h5A5A, 22'h2AAAAA, 4'b1010, 1'b1, 32'h5555_5555);
        send_item(1'b0, 16'hA5A5, 22'h155555, 4'b0101, 1'b1, 32'hAAAA_AAAA);
        send_item(1'b0, 16'hA5A5, 22'h2AAAAA, 4'b1111, 1'b1, 32'd0);
        send_item(1'b1, 16'hFFFF, 22'h3FFFFF, 4'hF, 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(input int n, input int pct);
        drain_results();
        write_event_reg(REG_ALLOC_ID, ID_W'($urandom));
        write_event_reg(REG_FREE_ID, ID_W'($urandom));
        idle_pct = pct;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 3)
                drain_results();
            send_random_item();
        end
    endtask

    task automatic test_table_full();
        drain_results();
        write_event_reg(REG_ALLOC_ID, ID_W'($urandom));
        write_event_reg(REG_FREE_ID, ID_W'($urandom));
        idle_pct = 30;
        while (tbl_count < DEPTH)
            send_item(1'b0, alloc_id, unused_pid(), ORDER_W'($urandom), 1'b1, $urandom);
        send_item(1'b0, alloc_id, unused_pid(), ORDER_W'($urandom), 1'b1, $urandom);
        send_item(1'b0, free_id, unused_pid(), ORDER_W'($urandom), 1'b0, $urandom);
        send_item(1'b1, ID_W'($urandom), PID_W'($urandom), ORDER_W'($urandom), 1'b1,
                  $urandom);
        send_item(1'b0, free_id, tbl_pid[0], ORDER_W'($urandom), 1'b0, $urandom);
        send_item(1'b0, alloc_id, tbl_pid[DEPTH-1], ORDER_W'($urandom), 1'b1, $urandom);
        send_item(1'b1, ID_W'($urandom), PID_W'($urandom), ORDER_W'($urandom), 1'b0,
                  $urandom);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result st %0d pid %h cur %h peak %h last %b",
                         $time, o_status, o_entry_pid, o_current_pages, o_peak_pages, o_last);
                fails++;
            end else begin
                due = results_due.pop_front();
                if (o_status !== due.status || o_entry_pid !== due.pid ||
                    o_current_pages !== due.cur || o_peak_pages !== due.peak ||
                    o_last !== due.last) begin
                    $display("%0t: expected st %0d pid %h cur %h peak %h last %b", $time,
                             due.status, due.pid, due.cur, due.peak, due.last);
                    $display("%0t: actual   st %0d pid %h cur %h peak %h last %b", $time,
                             o_status, o_entry_pid, o_current_pages, o_peak_pages, o_last);
                    fails++;
                end
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= REG_ALLOC_ID;
        i_cfg_wdata    <= '0;
        i_start        <= 1'b0;
        i_command      <= 1'b0;
        i_event_id     <= '0;
        i_task_pid     <= '0;
        i_order        <= '0;
        i_task_present <= 1'b0;
        i_initial_rss  <= '0;
        alloc_id  = '0;
        free_id   = '0;
        tbl_count = 0;
        fails     = 0;
        idle_pct  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_events();
        test_random_traffic(30, 0);
        test_random_traffic(30, 73);
        test_table_full();
        test_random_traffic(30, 7);
        drain_results();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pptm_pkg.sv
sv/pptm_cell.sv
sv/pptm_update.sv
sv/per_task_peak_memory_table.sv
bench/per_task_peak_memory_table_tb.sv
